// ===== sv/mbs_pkg.sv =====
package mbs_pkg;

  // default sizing
  localparam int DEF_ELEMENT_COUNT = 1024;
  localparam int DEF_STACK_DEPTH   = 2048;
  localparam int DEF_MARK_BITS     = 8;

  // fixed field widths of the stream payload
  localparam int OP_W     = 3;
  localparam int ELEM_W   = 10;
  localparam int OUT_CNT_W = 11;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_START     = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BATCH = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET     = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

endpackage

// ===== sv/marked_batch_stack_top.sv =====
// Marked set with a batch undo stack. Each input beat carries an operation
// (push, start batch, pop batch, reset, query) and an element id; each one
// returns exactly one result beat with the membership answer, the member
// count, an empty flag and an overflow flag. Membership lives in a mark store
// (one word per element, compared against the current generation mark) and
// entry order in a stack memory; both are RAMs with a registered read. One
// item is worked on at a time: push and query go through accept, mark store
// read and result load; start batch and reset go from accept straight to
// result load; pop batch walks back through the stack memory one entry at a
// time before the result load. After rst, and after a reset that wraps the
// mark, a clearing pass zeroes the mark store while s_tready stays low. A
// result waits in the output register while the next beat is accepted.
module marked_batch_stack_top
  #(
    parameter int ELEMENT_COUNT = mbs_pkg::DEF_ELEMENT_COUNT,
    parameter int STACK_DEPTH   = mbs_pkg::DEF_STACK_DEPTH,
    parameter int MARK_BITS     = mbs_pkg::DEF_MARK_BITS
  ) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [2:0] op, [12:3] elem, [15:13] zero
  input  logic [mbs_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] is_member, [11:1] member_count, [12] is_empty, [13] overflow,
  // [15:14] zero
  output logic [mbs_pkg::OUT_DATA_W-1:0] m_tdata
);

  import mbs_pkg::*;

  localparam int AW    = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam int ID_W  = $clog2(ELEMENT_COUNT + 1);   // id or marker code
  localparam int CNT_W = $clog2(ELEMENT_COUNT + 1);
  localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LEN_W = $clog2(STACK_DEPTH + 1);
  localparam int EXT_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  localparam logic [ID_W-1:0]  BATCH_CODE = ID_W'(ELEMENT_COUNT);
  localparam logic [AW-1:0]    CLR_LAST   = AW'(ELEMENT_COUNT - 1);
  localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(STACK_DEPTH);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;  // zero the mark store
  localparam logic [2:0] ST_IDLE   = 3'd1;  // take a beat
  localparam logic [2:0] ST_LOOKUP = 3'd2;  // mark word arrives
  localparam logic [2:0] ST_POP    = 3'd3;  // stack word arrives
  localparam logic [2:0] ST_FINISH = 3'd4;  // load the output register

  logic [2:0]           state;
  logic [AW-1:0]        clr_addr;
  logic [LEN_W-1:0]     len;
  logic [CNT_W-1:0]     members;
  logic [MARK_BITS-1:0] mark;
  logic                 wrap_pending;
  logic [OP_W-1:0]      op;
  logic [ELEM_W-1:0]    elem;
  logic                 hit;
  logic                 ovf;

  logic                 mark_we;
  logic [AW-1:0]        mark_waddr;
  logic [MARK_BITS-1:0] mark_wdata;
  logic [AW-1:0]        mark_raddr;
  logic [MARK_BITS-1:0] mark_rdata;
  logic                 stk_we;
  logic [SAW-1:0]       stk_waddr;
  logic [ID_W-1:0]      stk_wdata;
  logic [SAW-1:0]       stk_raddr;
  logic [ID_W-1:0]      stk_rdata;

  logic [OP_W-1:0]      op_in;
  logic [ELEM_W-1:0]    elem_in;
  logic                 accept;
  logic [LEN_W-1:0]     len_dec;
  logic                 full;
  logic                 in_range;
  logic                 marked;
  logic                 code_is_marker;
  logic [MARK_BITS-1:0] mark_inc;
  logic [EXT_W-1:0]     cnt_ext;

  assign op_in    = s_tdata[OP_W-1:0];
  assign elem_in  = s_tdata[OP_W +: ELEM_W];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign len_dec  = len - LEN_W'(1);
  assign full     = (len == LEN_FULL);
  assign in_range = (32'(elem) < ELEMENT_COUNT);
  assign marked   = in_range && (mark_rdata == mark);
  assign code_is_marker = (32'(stk_rdata) >= ELEMENT_COUNT);
  assign mark_inc = mark + MARK_BITS'(1);
  assign cnt_ext  = EXT_W'(members);

  mbs_ram #(.DEPTH(ELEMENT_COUNT), .WIDTH(MARK_BITS), .ADDR_W(AW)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  mbs_ram #(.DEPTH(STACK_DEPTH), .WIDTH(ID_W), .ADDR_W(SAW)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Memory port control. Only one item is in flight and every write lands
  // before the next beat's read is issued, so no forwarding is needed.
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = AW'(elem);
    mark_wdata = mark;
    mark_raddr = AW'(elem_in);
    stk_we     = 1'b0;
    stk_waddr  = len[SAW-1:0];
    stk_wdata  = BATCH_CODE;
    stk_raddr  = len_dec[SAW-1:0];
    unique case (state)
      ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_addr;
        mark_wdata = '0;
      end
      ST_IDLE: begin
        if (accept && op_in == OP_START && !full) begin
          stk_we = 1'b1;
        end
      end
      ST_LOOKUP: begin
        if (op == OP_PUSH && in_range && !marked && !full) begin
          mark_we   = 1'b1;
          stk_we    = 1'b1;
          stk_wdata = ID_W'(elem);
        end
      end
      ST_POP: begin
        if (!code_is_marker) begin
          // unmark the popped id
          mark_we    = 1'b1;
          mark_waddr = stk_rdata[AW-1:0];
          mark_wdata = '0;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      len          <= '0;
      members      <= '0;
      mark         <= MARK_BITS'(1);
      wrap_pending <= 1'b0;
      m_tvalid     <= 1'b0;
      hit          <= 1'b0;
      ovf          <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op    <= op_in;
            elem  <= elem_in;
            hit   <= 1'b0;
            ovf   <= 1'b0;
            state <= ST_FINISH;
            case (op_in) inside
              OP_PUSH, OP_QUERY: begin
                state <= ST_LOOKUP;
              end
              OP_START: begin
                if (full) begin
                  ovf <= 1'b1;
                end else begin
                  len <= len + LEN_W'(1);
                end
              end
              OP_POP_BATCH: begin
                if (len != '0) begin
                  len   <= len_dec;
                  state <= ST_POP;
                end
              end
              OP_RESET: begin
                len     <= '0;
                members <= '0;
                if (mark_inc == '0) begin
                  // mark wrapped: store is cleared after the result goes out
                  mark         <= MARK_BITS'(1);
                  wrap_pending <= 1'b1;
                end else begin
                  mark <= mark_inc;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOKUP: begin
          state <= ST_FINISH;
          if (op == OP_QUERY) begin
            hit <= marked;
          end else if (in_range && !marked) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              len     <= len + LEN_W'(1);
              members <= members + CNT_W'(1);
            end
          end
        end
        ST_POP: begin
          if (code_is_marker) begin
            state <= ST_FINISH;
          end else begin
            if (members != '0) begin
              members <= members - CNT_W'(1);
            end
            if (len == '0) begin
              state <= ST_FINISH;
            end else begin
              len <= len_dec;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid     <= 1'b1;
            wrap_pending <= 1'b0;
            state        <= wrap_pending ? ST_CLEAR : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded with m_tvalid
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, ovf, (members == '0), cnt_ext[OUT_CNT_W-1:0], hit};
    end
  end

endmodule

// ===== sv/mbs_ram.sv =====
module mbs_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
